// ===== sv/assert_macros.svh =====
// Assertion macros for the reverb block.
// Each macro expects a signal named clk, and AST also one named rst, in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define AST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset too.
`define AST_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/carv_pkg.sv =====
// Package for the comb/allpass reverb: transaction types, tunings and
// fixed-point helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package carv_pkg;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               frame_last;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               out_last;
  } out_t;

  localparam int unsigned COMB_TUNE [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
  localparam int unsigned AP_TUNE   [4] = '{556, 441, 341, 225};

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_WET    = 2'd1;
  localparam logic [1:0] REG_ROOM   = 2'd2;
  localparam logic [1:0] REG_DAMP   = 2'd3;

  // floor((p + 2^15) / 2^16)
  function automatic logic signed [24:0] rnd16(input logic signed [42:0] p);
    logic signed [42:0] t;
    t = p + 43'sd32768;
    return 25'(t >>> 16);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) return 24'sh7FFFFF;
    if (v < -28'sd8388608) return 24'sh800000;
    return 24'(v);
  endfunction

endpackage
`default_nettype wire

// ===== sv/comb_allpass_reverb.sv =====
// Top level of the mono comb/allpass reverb with its APB register port.
// Depends on carv_pkg and assert_macros.svh.
//
// One sample is accepted at a time. With reverb enabled, a sample passes
// every comb (CRD, C1 to C5), then every allpass (ARD, A1), then the mix
// (M0 to M4) and hand-off (DONE), sharing one 24x18 multiplier and each
// delay memory's one read and one write address. A disabled sample goes
// from intake straight to hand-off. After reset a clearing pass zeroes the
// delay memories, max(COMB_COUNT*COMB_DEPTH_MAX, ALLPASS_COUNT*ALLPASS_DEPTH_MAX)
// addresses; no sample is taken until it ends, though register writes are.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module comb_allpass_reverb #(
  parameter int FS_HZ             = 48000,
  parameter int COMB_COUNT        = 8,
  parameter int ALLPASS_COUNT     = 4,
  parameter int COMB_DEPTH_MAX    = 2048,
  parameter int ALLPASS_DEPTH_MAX = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire carv_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output carv_pkg::out_t     out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import carv_pkg::*;

  localparam int CKW  = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
  localparam int AKW  = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
  localparam int CPW  = $clog2(COMB_DEPTH_MAX);
  localparam int APW  = $clog2(ALLPASS_DEPTH_MAX);
  localparam int CTOT = COMB_COUNT * COMB_DEPTH_MAX;
  localparam int ATOT = ALLPASS_COUNT * ALLPASS_DEPTH_MAX;
  localparam int CAW  = $clog2(CTOT);
  localparam int AAW  = $clog2(ATOT);
  localparam int CLR_N = (CTOT > ATOT) ? CTOT : ATOT;
  localparam int CLW  = $clog2(CLR_N);

  function automatic int unsigned dlen(input int unsigned tune, input int unsigned cap);
    longint unsigned n;
    n = (longint'(tune) * longint'(FS_HZ)) / 44100;
    if (n == 0) n = 1;
    if (n > cap) n = cap;
    return int'(n);
  endfunction

  localparam int unsigned COMB_LEN [8] = '{
    dlen(COMB_TUNE[0], COMB_DEPTH_MAX), dlen(COMB_TUNE[1], COMB_DEPTH_MAX),
    dlen(COMB_TUNE[2], COMB_DEPTH_MAX), dlen(COMB_TUNE[3], COMB_DEPTH_MAX),
    dlen(COMB_TUNE[4], COMB_DEPTH_MAX), dlen(COMB_TUNE[5], COMB_DEPTH_MAX),
    dlen(COMB_TUNE[6], COMB_DEPTH_MAX), dlen(COMB_TUNE[7], COMB_DEPTH_MAX)};
  localparam int unsigned AP_LEN [4] = '{
    dlen(AP_TUNE[0], ALLPASS_DEPTH_MAX), dlen(AP_TUNE[1], ALLPASS_DEPTH_MAX),
    dlen(AP_TUNE[2], ALLPASS_DEPTH_MAX), dlen(AP_TUNE[3], ALLPASS_DEPTH_MAX)};

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_CLR  = 5'd1;
  localparam logic [4:0] ST_CRD  = 5'd2;
  localparam logic [4:0] ST_C1   = 5'd3;
  localparam logic [4:0] ST_C2   = 5'd4;
  localparam logic [4:0] ST_C3   = 5'd5;
  localparam logic [4:0] ST_C4   = 5'd6;
  localparam logic [4:0] ST_C5   = 5'd7;
  localparam logic [4:0] ST_ARD  = 5'd8;
  localparam logic [4:0] ST_A1   = 5'd9;
  localparam logic [4:0] ST_M0   = 5'd10;
  localparam logic [4:0] ST_M1   = 5'd11;
  localparam logic [4:0] ST_M2   = 5'd12;
  localparam logic [4:0] ST_M3   = 5'd13;
  localparam logic [4:0] ST_M4   = 5'd14;
  localparam logic [4:0] ST_DONE = 5'd15;

  // registers
  logic        enable;
  logic [15:0] wet_level, room_level, damping_level;

  logic [4:0]  state;
  logic [CLW-1:0] clr;
  logic [CKW-1:0] k;
  logic [AKW-1:0] ka;
  logic [CPW-1:0] cpos [COMB_COUNT];
  logic [APW-1:0] apos [ALLPASS_COUNT];
  logic signed [23:0] lp [COMB_COUNT];

  logic signed [15:0] x_r;
  logic        last_r;
  logic [16:0] fb_r, damp2_r, dry_r;
  logic [15:0] damp1_r, wet_r;
  logic signed [23:0] y_r, ap_r;
  logic signed [26:0] sum_r;
  logic signed [41:0] prod_r;
  logic signed [42:0] acc_r;
  logic signed [57:0] pw_r;
  out_t        res;

  logic signed [23:0] cmem [CTOT];
  logic signed [23:0] amem [ATOT];
  logic signed [23:0] c_rdata, a_rdata;

  // APB
  logic wr;
  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE: prdata = {31'd0, enable};
      REG_WET:    prdata = {16'd0, wet_level};
      REG_ROOM:   prdata = {16'd0, room_level};
      REG_DAMP:   prdata = {16'd0, damping_level};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      wet_level     <= 16'd0;
      room_level    <= 16'd32768;
      damping_level <= 16'd32768;
    end else if (wr) begin
      case (paddr[3:2])
        REG_ENABLE: enable        <= pwdata[0];
        REG_WET:    wet_level     <= pwdata[15:0];
        REG_ROOM:   room_level    <= pwdata[15:0];
        REG_DAMP:   damping_level <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // coefficients
  logic [31:0] room_m, damp_m, wet_m;
  assign room_m = 32'(room_level) * 32'd18350;
  assign damp_m = 32'(damping_level) * 32'd26214;
  assign wet_m  = 32'(wet_level) * 32'd26214;

  logic in_acc;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // shared multiplier
  logic signed [23:0] mul_a;
  logic [16:0]        mul_c;
  logic signed [41:0] mul_p;
  always_comb begin
    case (state)
      ST_C1:   begin mul_a = c_rdata; mul_c = damp2_r; end
      ST_C2:   begin mul_a = lp[k]; mul_c = 17'(damp1_r); end
      ST_C4:   begin mul_a = lp[k]; mul_c = fb_r; end
      ST_M0:   begin mul_a = 24'(x_r); mul_c = dry_r; end
      ST_M1:   begin mul_a = ap_r; mul_c = 17'(wet_r); end
      default: begin mul_a = ap_r; mul_c = 17'(wet_r); end
    endcase
  end
  assign mul_p = mul_a * $signed({1'b0, mul_c});

  // addresses and datapath
  logic [CPW:0] clen, cinc;
  logic [APW:0] alen, ainc;
  logic [CAW-1:0] c_addr;
  logic [AAW-1:0] a_addr;
  logic signed [23:0] lp_new, c_wval, ap_o, a_wval;
  logic signed [42:0] p_sum;
  logic c_we, a_we;
  logic [CAW-1:0] c_waddr;
  logic [AAW-1:0] a_waddr;
  logic signed [23:0] c_wdata, a_wdata;

  assign clen   = (CPW + 1)'(COMB_LEN[k]);
  assign alen   = (APW + 1)'(AP_LEN[ka]);
  assign cinc   = (CPW + 1)'(cpos[k]) + 1'b1;
  assign ainc   = (APW + 1)'(apos[ka]) + 1'b1;
  assign c_addr = CAW'(k) * CAW'(COMB_DEPTH_MAX) + CAW'(cpos[k]);
  assign a_addr = AAW'(ka) * AAW'(ALLPASS_DEPTH_MAX) + AAW'(apos[ka]);
  assign p_sum  = 43'(acc_r) + 43'(prod_r);
  assign lp_new = sat24(28'(rnd16(p_sum)));
  assign c_wval = sat24(28'(x_r) + 28'(rnd16(43'(prod_r))));
  assign ap_o   = sat24(28'(a_rdata) - 28'(ap_r));
  assign a_wval = sat24(28'(ap_r) + ((28'(a_rdata) + 28'sd1) >>> 1));

  always_comb begin
    c_we = 1'b0; c_waddr = c_addr; c_wdata = c_wval;
    a_we = 1'b0; a_waddr = a_addr; a_wdata = a_wval;
    if (state == ST_CLR) begin
      c_we = (32'(clr) < CTOT);
      a_we = (32'(clr) < ATOT);
      c_waddr = clr[CAW-1:0];
      a_waddr = clr[AAW-1:0];
      c_wdata = '0;
      a_wdata = '0;
    end else if (state == ST_C5) begin
      c_we = 1'b1;
    end else if (state == ST_A1) begin
      a_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    c_rdata <= cmem[c_addr];
    a_rdata <= amem[a_addr];
    if (c_we) cmem[c_waddr] <= c_wdata;
    if (a_we) amem[a_waddr] <= a_wdata;
  end

  // mix
  logic        neg;
  logic [57:0] absv;
  logic [24:0] mag;
  logic [15:0] magc;
  assign neg  = pw_r[57];
  assign absv = neg ? 58'(-pw_r) : 58'(pw_r);
  assign mag  = absv[57:33];
  assign magc = (mag > 25'd32767) ? 16'd32767 : 16'(mag);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr       <= '0;
      k         <= '0;
      ka        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < COMB_COUNT; i++) begin
        cpos[i] <= '0;
        lp[i]   <= '0;
      end
      for (int i = 0; i < ALLPASS_COUNT; i++) apos[i] <= '0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) out_valid <= 1'b0;
      case (state)
        ST_CLR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == CLR_N - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            x_r     <= in_data.sample;
            last_r  <= in_data.frame_last;
            fb_r    <= 17'd45875 + 17'(room_m[31:16]);
            damp1_r <= damp_m[31:16];
            damp2_r <= 17'd65536 - 17'(damp_m[31:16]);
            dry_r   <= 17'd65536 - 17'(wet_m[31:16]);
            wet_r   <= wet_level;
            sum_r   <= '0;
            k       <= '0;
            ka      <= '0;
            if (enable) begin
              state <= ST_CRD;
            end else begin
              res.out_sample <= in_data.sample;
              res.out_last   <= in_data.frame_last;
              state          <= ST_DONE;
            end
          end
        end
        ST_CRD: state <= ST_C1;
        ST_C1: begin
          y_r    <= c_rdata;
          prod_r <= mul_p;
          state  <= ST_C2;
        end
        ST_C2: begin
          acc_r  <= 43'(prod_r);
          prod_r <= mul_p;
          state  <= ST_C3;
        end
        ST_C3: begin
          lp[k] <= lp_new;
          sum_r <= sum_r + 27'(y_r);
          state <= ST_C4;
        end
        ST_C4: begin
          prod_r <= mul_p;
          state  <= ST_C5;
        end
        ST_C5: begin
          cpos[k] <= (cinc >= clen) ? '0 : cinc[CPW-1:0];
          if (k == CKW'(COMB_COUNT - 1)) begin
            ap_r  <= sat24(28'(sum_r));
            state <= ST_ARD;
          end else begin
            k     <= k + 1'b1;
            state <= ST_CRD;
          end
        end
        ST_ARD: state <= ST_A1;
        ST_A1: begin
          ap_r     <= ap_o;
          apos[ka] <= (ainc >= alen) ? '0 : ainc[APW-1:0];
          if (ka == AKW'(ALLPASS_COUNT - 1)) begin
            state <= ST_M0;
          end else begin
            ka    <= ka + 1'b1;
            state <= ST_ARD;
          end
        end
        ST_M0: begin
          prod_r <= mul_p;
          state  <= ST_M1;
        end
        ST_M1: begin
          acc_r  <= 43'(prod_r) <<< 2;
          prod_r <= mul_p;
          state  <= ST_M2;
        end
        ST_M2: begin
          acc_r <= p_sum;
          state <= ST_M3;
        end
        ST_M3: begin
          pw_r  <= (58'(acc_r) <<< 15) - 58'(acc_r);
          state <= ST_M4;
        end
        ST_M4: begin
          res.out_sample <= neg ? -magc : magc;
          res.out_last   <= last_r;
          state          <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `AST(a_bypass, (in_acc && !enable) |=> (state == ST_DONE), "bypass did not finish")
  `AST(a_out_src, $rose(out_valid) |-> ($past(state) == ST_DONE), "result without completion")
  `AST(a_comb_idx, (state == ST_C5) |-> (32'(k) < COMB_COUNT), "comb index out of range")

endmodule
`default_nettype wire

// ===== tb/carv_checker.sv =====
// Checker for the comb/allpass reverb: watches both sample channels and
// the register port, predicts each output transaction and compares it.
// Depends on carv_pkg.
`timescale 1ns / 1ps
module carv_checker #(
  parameter int FS_HZ             = 48000,
  parameter int COMB_COUNT        = 8,
  parameter int ALLPASS_COUNT     = 4,
  parameter int COMB_DEPTH_MAX    = 2048,
  parameter int ALLPASS_DEPTH_MAX = 1024
) (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input carv_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input carv_pkg::out_t out_data,
  input logic           psel,
  input logic           penable,
  input logic           pwrite,
  input logic [3:0]     paddr,
  input logic [31:0]    pwdata,
  input logic           pready,
  output int            fail_count,
  output int            pending
);
  import carv_pkg::*;

  logic        enable_q;
  logic [15:0] wet_q, room_q, damp_q;
  int          comb_line [COMB_COUNT][COMB_DEPTH_MAX];
  int          comb_lp [COMB_COUNT];
  int          comb_pos [COMB_COUNT];
  int          ap_line [ALLPASS_COUNT][ALLPASS_DEPTH_MAX];
  int          ap_pos [ALLPASS_COUNT];
  out_t        expected_q [$];

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint round_q16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  function automatic int line_len(int tune, int cap);
    longint n;
    n = (longint'(tune) * FS_HZ) / 44100;
    if (n == 0) n = 1;
    if (n > cap) n = cap;
    return int'(n);
  endfunction

  function automatic out_t reverb_sample(in_t item);
    out_t   r;
    longint x, fb, d1, d2, dry, sum, ap, y, lp, b, o, acc, prod, mag;
    int     len, pos;
    x = item.sample;
    r.out_last = item.frame_last;
    if (!enable_q) begin
      r.out_sample = item.sample;
      return r;
    end
    fb  = 45875 + ((longint'(room_q) * 18350) >> 16);
    d1  = (longint'(damp_q) * 26214) >> 16;
    d2  = 65536 - d1;
    dry = 65536 - ((longint'(wet_q) * 26214) >> 16);
    sum = 0;
    for (int k = 0; k < COMB_COUNT; k++) begin
      len = line_len(COMB_TUNE[k % 8], COMB_DEPTH_MAX);
      pos = comb_pos[k];
      if (pos >= len) pos = 0;
      y = comb_line[k][pos];
      lp = clamp24(round_q16(y * d2 + longint'(comb_lp[k]) * d1));
      comb_lp[k] = int'(lp);
      comb_line[k][pos] = int'(clamp24(x + round_q16(lp * fb)));
      pos++;
      comb_pos[k] = (pos >= len) ? 0 : pos;
      sum += y;
    end
    ap = clamp24(sum);
    for (int k = 0; k < ALLPASS_COUNT; k++) begin
      len = line_len(AP_TUNE[k % 4], ALLPASS_DEPTH_MAX);
      pos = ap_pos[k];
      if (pos >= len) pos = 0;
      b = ap_line[k][pos];
      o = clamp24(b - ap);
      ap_line[k][pos] = int'(clamp24(ap + round_q16(b * 32768)));
      pos++;
      ap_pos[k] = (pos >= len) ? 0 : pos;
      ap = o;
    end
    acc  = 4 * x * dry + ap * longint'(wet_q);
    prod = acc * 32767;
    mag  = (prod < 0) ? -prod : prod;
    mag  = mag >> 33;
    if (mag > 32767) mag = 32767;
    r.out_sample = 16'((prod < 0) ? -mag : mag);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_t got, want;
    int   errs;
    errs = 0;
    if (rst) begin
      enable_q <= 1'b0;
      wet_q <= '0;
      room_q <= 16'd32768;
      damp_q <= 16'd32768;
      for (int k = 0; k < COMB_COUNT; k++) begin
        comb_lp[k] = 0;
        comb_pos[k] = 0;
        for (int i = 0; i < COMB_DEPTH_MAX; i++) comb_line[k][i] = 0;
      end
      for (int k = 0; k < ALLPASS_COUNT; k++) begin
        ap_pos[k] = 0;
        for (int i = 0; i < ALLPASS_DEPTH_MAX; i++) ap_line[k][i] = 0;
      end
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ENABLE: enable_q <= pwdata[0];
          REG_WET:    wet_q <= pwdata[15:0];
          REG_ROOM:   room_q <= pwdata[15:0];
          REG_DAMP:   damp_q <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(reverb_sample(in_data));
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_q.size() == 0) begin
          $error("out transaction with nothing expected: %0d", got.out_sample);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (got.out_sample !== want.out_sample) begin
            $error("out_sample expected %0d got %0d", want.out_sample, got.out_sample);
            errs++;
          end
          if (got.out_last !== want.out_last) begin
            $error("out_last expected %0b got %0b", want.out_last, got.out_last);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== tb/comb_allpass_reverb_tb.sv =====
// Top of the reverb testbench: clock, reset, register writes, sample
// stimulus with random idling, and the verdict. Depends on carv_pkg,
// carv_checker and the comb_allpass_reverb RTL.
`timescale 1ns / 1ps
module comb_allpass_reverb_tb;
  import carv_pkg::*;

  localparam int WATCHDOG = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          idle_cycles = 0, sent = 0;

  always #10 clk = ~clk;

  comb_allpass_reverb DUT (.*);

  carv_checker checker_i (.*);

  // stall the receiver at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] s, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{sample: s, frame_last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    sent++;
  endtask

  task automatic set_mix(logic en, logic [15:0] wet, logic [15:0] room, logic [15:0] damp);
    drain();
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_WET, {16'd0, wet});
    write_reg(REG_ROOM, {16'd0, room});
    write_reg(REG_DAMP, {16'd0, damp});
  endtask

  task automatic random_burst(int n);
    logic signed [15:0] s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: s = 16'($urandom);
        1: s = ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
        default: s = 16'($signed(16'($urandom_range(4095))) - 2048);
      endcase
      send_sample(s, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // disabled pass-through, extremes
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shFFFF, 1'b1);
    // full wet, largest room, no damping: impulse then saturating input
    set_mix(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_sample(16'sh7FFF, 1'b1);
    for (int i = 0; i < 6; i++) send_sample(16'sh8000, i[0]);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh0000, 1'b0);
    // no wet, smallest room, full damping
    set_mix(1'b1, 16'h0000, 16'h0000, 16'hFFFF);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh1234, 1'b0);
    // disable mid-stream keeps delay contents
    set_mix(1'b0, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'sh5555, 1'b1);
    send_sample(16'shAAAA, 1'b0);

    send_idle_pct = 7; recv_idle_pct = 46;
    set_mix(1'b1, 16'h8000, 16'h8000, 16'h8000);
    random_burst(250);
    set_mix(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    random_burst(150);
    send_idle_pct = 46; recv_idle_pct = 7;
    set_mix(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
    random_burst(150);
    set_mix(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    random_burst(50);
    send_idle_pct = 0; recv_idle_pct = 0;
    set_mix(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    random_burst(200);
    set_mix(1'b1, 16'h0000, 16'h0000, 16'hFFFF);
    random_burst(200);
    drain();
    $display("Covered %0d samples over pass-through, extreme and random mix settings,", sent);
    $display("with sender and receiver idling in turn and a full drain between phases.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/carv_pkg.sv
sv/comb_allpass_reverb.sv
tb/carv_checker.sv
tb/comb_allpass_reverb_tb.sv
